// ----- design/sobel_pkg.sv -----
// Package for the Sobel edge threshold block.
// Holds frame geometry, field widths and the request/response payload types.
// Depends on nothing; imported by sobel_edge_threshold, sobel_edge_checker and sobel_edge_threshold_tb.
`default_nettype none

package sobel_pkg;

   localparam int IMAGE_WIDTH  = 160;
   localparam int IMAGE_HEIGHT = 120;

   localparam int COL_W = $clog2(IMAGE_WIDTH);
   localparam int ROW_W = $clog2(IMAGE_HEIGHT);

   localparam int PIXEL_W  = 8;
   localparam int THRESH_W = 10;
   localparam int COUNT_W  = 15;
   localparam int ROW_IDX_W = 7;
   localparam int COL_IDX_W = 8;

   localparam logic [THRESH_W-1:0] THRESHOLD_RESET = THRESH_W'(128);
   localparam logic [COUNT_W-1:0]  COUNT_MAX       = {COUNT_W{1'b1}};

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               frame_start;
   } req_type;

   typedef struct packed {
      logic                 edge_res;
      logic [ROW_IDX_W-1:0] row_index;
      logic [COL_IDX_W-1:0] col_index;
      logic [COUNT_W-1:0]   edge_count;
      logic                 frame_last;
   } rsp_type;

   // A request after position tracking, held in the input stage.
   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic [ROW_W-1:0]   row;
      logic [COL_W-1:0]   col;
      logic               frame_start;
      logic               last;
   } stage_type;

endpackage : sobel_pkg

`default_nettype wire

// ----- design/sobel_edge_threshold.sv -----
// Sobel 3x3 edge detector with threshold, edge count and frame position.
// Throughput: one request per cycle while no held response stalls the
// input stage; the line store read and the window sums each take one
// register stage, and a request enters whenever the input stage moves.
// Reset: position, edge count, window and valid flags clear and the threshold
// returns to 128; the two line stores are not cleared.
`default_nettype none

module sobel_edge_threshold
   import sobel_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,

   input  wire logic                req_valid,
   output      logic                req_ready,
   input  wire req_type             req_data,

   output      logic                rsp_valid,
   input  wire logic                rsp_ready,
   output      rsp_type             rsp_data,

   input  wire logic                csr_wr_en,
   input  wire logic [THRESH_W-1:0] csr_wr_data
);

   // Configuration register.
   logic [THRESH_W-1:0] threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
      end else if (csr_wr_en) begin
         threshold_ff <= csr_wr_data;
      end
   end

   // Position tracking happens on acceptance, since the next position depends
   // only on the current one and the frame start flag. That lets the line
   // store read address be known at the same edge that takes the request.
   logic [ROW_W-1:0] row_pos_ff, row_pos_in;
   logic [COL_W-1:0] col_pos_ff, col_pos_in;
   logic [ROW_W-1:0] cur_row;
   logic [COL_W-1:0] cur_col;
   logic             cur_last;
   logic             req_accept;

   assign req_accept = req_valid && req_ready;

   always_comb begin
      cur_row  = req_data.frame_start ? '0 : row_pos_ff;
      cur_col  = req_data.frame_start ? '0 : col_pos_ff;
      cur_last = (cur_row == ROW_W'(IMAGE_HEIGHT - 1)) &&
                 (cur_col == COL_W'(IMAGE_WIDTH - 1));
      if (cur_last) begin
         row_pos_in = '0;
         col_pos_in = '0;
      end else if (cur_col == COL_W'(IMAGE_WIDTH - 1)) begin
         row_pos_in = cur_row + ROW_W'(1);
         col_pos_in = '0;
      end else begin
         row_pos_in = cur_row;
         col_pos_in = cur_col + COL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_pos_ff <= '0;
         col_pos_ff <= '0;
      end else if (req_accept) begin
         row_pos_ff <= row_pos_in;
         col_pos_ff <= col_pos_in;
      end
   end

   // Input stage register.
   stage_type s1_ff;
   logic      s1_valid_ff;
   logic      s1_produce;
   logic      s1_move;
   logic      out_free;

   assign s1_produce = (s1_ff.row >= ROW_W'(2)) && (s1_ff.col >= COL_W'(2));
   assign out_free   = !rsp_valid || rsp_ready;
   // The input stage drains when the response register can take its result,
   // or at once when the pixel completes no window.
   assign s1_move    = s1_valid_ff && (out_free || !s1_produce);
   assign req_ready  = !s1_valid_ff || s1_move;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ff.pixel       <= req_data.pixel;
         s1_ff.row         <= cur_row;
         s1_ff.col         <= cur_col;
         s1_ff.frame_start <= req_data.frame_start;
         s1_ff.last        <= cur_last;
      end
   end

   // Line stores. The read for a request is registered at its acceptance; the
   // write for the request in the input stage lands at the same edge. When both
   // hit the same column (a frame start right after column zero), the data
   // being written is forwarded instead of the stale memory word.
   logic [PIXEL_W-1:0] upper_mem  [IMAGE_WIDTH];
   logic [PIXEL_W-1:0] middle_mem [IMAGE_WIDTH];
   logic [PIXEL_W-1:0] up_rd_ff, mid_rd_ff;
   logic [PIXEL_W-1:0] up_fwd_ff, mid_fwd_ff;
   logic               fwd_ff;
   logic [PIXEL_W-1:0] up_px, mid_px;

   assign up_px  = fwd_ff ? up_fwd_ff  : up_rd_ff;
   assign mid_px = fwd_ff ? mid_fwd_ff : mid_rd_ff;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         up_rd_ff  <= upper_mem[cur_col];
         mid_rd_ff <= middle_mem[cur_col];
      end
      if (s1_move) begin
         upper_mem[s1_ff.col]  <= mid_px;
         middle_mem[s1_ff.col] <= s1_ff.pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (req_accept) begin
         fwd_ff <= s1_move && (s1_ff.col == cur_col);
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         up_fwd_ff  <= mid_px;
         mid_fwd_ff <= s1_ff.pixel;
      end
   end

   // Window: the two older columns are stored, the newest column is the
   // line store output plus the incoming pixel. Index 0 is the top row.
   logic [PIXEL_W-1:0] win_left_ff [3];
   logic [PIXEL_W-1:0] win_mid_ff  [3];
   logic [PIXEL_W-1:0] win_right   [3];

   assign win_right[0] = up_px;
   assign win_right[1] = mid_px;
   assign win_right[2] = s1_ff.pixel;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            win_left_ff[i] <= '0;
            win_mid_ff[i]  <= '0;
         end
      end else if (s1_move) begin
         for (int i = 0; i < 3; i++) begin
            win_left_ff[i] <= win_mid_ff[i];
            win_mid_ff[i]  <= win_right[i];
         end
      end
   end

   // Sobel sums over the shifted window. The standard kernels reduce to
   // weighted column sums for Gx and weighted row sums for Gy.
   logic [THRESH_W-1:0]   sum_right, sum_left, sum_bottom, sum_top;
   logic signed [THRESH_W:0] grad_x, grad_y;
   logic [THRESH_W-1:0]   abs_x, abs_y;
   logic                  is_edge;
   logic [COUNT_W-1:0]    count_base, count_new;
   logic [COUNT_W-1:0]    edge_total_ff, edge_total_in;

   always_comb begin
      sum_right  = THRESH_W'(win_right[0]) + THRESH_W'({win_right[1], 1'b0})
                 + THRESH_W'(win_right[2]);
      sum_left   = THRESH_W'(win_left_ff[0]) + THRESH_W'({win_left_ff[1], 1'b0})
                 + THRESH_W'(win_left_ff[2]);
      sum_bottom = THRESH_W'(win_left_ff[2]) + THRESH_W'({win_mid_ff[2], 1'b0})
                 + THRESH_W'(win_right[2]);
      sum_top    = THRESH_W'(win_left_ff[0]) + THRESH_W'({win_mid_ff[0], 1'b0})
                 + THRESH_W'(win_right[0]);
      grad_x = $signed({1'b0, sum_right})  - $signed({1'b0, sum_left});
      grad_y = $signed({1'b0, sum_bottom}) - $signed({1'b0, sum_top});
      abs_x  = grad_x[THRESH_W] ? THRESH_W'(-grad_x) : grad_x[THRESH_W-1:0];
      abs_y  = grad_y[THRESH_W] ? THRESH_W'(-grad_y) : grad_y[THRESH_W-1:0];
      is_edge = (abs_x > threshold_ff) || (abs_y > threshold_ff);

      // A frame start clears the count before this pixel counts; the count
      // saturates rather than wrapping.
      count_base = s1_ff.frame_start ? '0 : edge_total_ff;
      if (s1_produce && is_edge && (count_base != COUNT_MAX)) begin
         count_new = count_base + COUNT_W'(1);
      end else begin
         count_new = count_base;
      end
      edge_total_in = s1_ff.last ? '0 : count_new;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_total_ff <= '0;
      end else if (s1_move) begin
         edge_total_ff <= edge_total_in;
      end
   end

   // Response register.
   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_move && s1_produce) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move && s1_produce) begin
         rsp_ff.edge_res   <= is_edge;
         rsp_ff.row_index  <= ROW_IDX_W'(s1_ff.row - ROW_W'(2));
         rsp_ff.col_index  <= COL_IDX_W'(s1_ff.col - COL_W'(2));
         rsp_ff.edge_count <= count_new;
         rsp_ff.frame_last <= s1_ff.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The tracked position never leaves the frame.
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (s1_ff.col < COL_W'(IMAGE_WIDTH)) &&
                      (s1_ff.row < ROW_W'(IMAGE_HEIGHT)))
      else $error("input stage position outside the frame");

   // A frame start request lands at row zero, column zero of the input stage.
   assert property (@(posedge clock) disable iff (reset)
      req_accept && req_data.frame_start |=> (s1_ff.row == '0) && (s1_ff.col == '0))
      else $error("frame start did not restart the position");

   // The last window of a frame sits at the bottom right corner.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.frame_last |->
         (rsp_ff.row_index == ROW_IDX_W'(IMAGE_HEIGHT - 3)) &&
         (rsp_ff.col_index == COL_IDX_W'(IMAGE_WIDTH - 3)))
      else $error("frame last flag away from the final window");

   // A non-edge window never raises the count above the running total.
   assert property (@(posedge clock) disable iff (reset)
      s1_move && s1_produce && !is_edge |-> count_new == count_base)
      else $error("edge count moved without an edge");

endmodule : sobel_edge_threshold

`default_nettype wire

// ----- bench/sobel_edge_checker.sv -----
`timescale 1ns / 100ps
// Checker for the Sobel edge threshold block: watches both channels and the
// threshold port, predicts each response and compares it field by field.
// Depends on sobel_pkg for the payload types, frame geometry and widths.

module sobel_edge_checker
   import sobel_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_ready,
   input  wire req_type             req_data,
   input  wire logic                rsp_valid,
   input  wire logic                rsp_ready,
   input  wire rsp_type             rsp_data,
   input  wire logic                csr_wr_en,
   input  wire logic [THRESH_W-1:0] csr_wr_data,
   output int                       mismatch_count,
   output int                       outstanding,
   output int                       windows_checked,
   output int                       edges_seen,
   output int                       frame_ends
);

   // Predictor state: the two previous rows, the 3x3 window, the frame
   // position, the running edge count and the threshold in force.
   logic [PIXEL_W-1:0]  store_two_up [IMAGE_WIDTH];
   logic [PIXEL_W-1:0]  store_one_up [IMAGE_WIDTH];
   logic [PIXEL_W-1:0]  win [3][3];
   int unsigned         at_row;
   int unsigned         at_col;
   int unsigned         frame_edges;
   logic [THRESH_W-1:0] threshold;
   rsp_type             expected_q [$];

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic predict_pixel(input req_type rq);
      logic [PIXEL_W-1:0] two_up;
      logic [PIXEL_W-1:0] one_up;
      int unsigned        r;
      int unsigned        c;
      int                 gx;
      int                 gy;
      bit                 at_end;
      bit                 edge_hit;
      rsp_type            want;
      if (rq.frame_start) begin
         at_row = 0;
         at_col = 0;
         frame_edges = 0;
      end
      r = at_row;
      c = at_col;
      if (c >= IMAGE_WIDTH) begin
         c = 0;
      end
      two_up = store_two_up[c];
      one_up = store_one_up[c];
      store_two_up[c] = one_up;
      store_one_up[c] = rq.pixel;
      for (int i = 0; i < 3; i++) begin
         win[i][0] = win[i][1];
         win[i][1] = win[i][2];
      end
      win[0][2] = two_up;
      win[1][2] = one_up;
      win[2][2] = rq.pixel;
      at_end = (r == IMAGE_HEIGHT - 1) && (c == IMAGE_WIDTH - 1);
      if (r >= 2 && c >= 2) begin
         gx = int'(win[0][2]) + 2 * int'(win[1][2]) + int'(win[2][2])
            - int'(win[0][0]) - 2 * int'(win[1][0]) - int'(win[2][0]);
         gy = int'(win[2][0]) + 2 * int'(win[2][1]) + int'(win[2][2])
            - int'(win[0][0]) - 2 * int'(win[0][1]) - int'(win[0][2]);
         if (gx < 0) begin
            gx = -gx;
         end
         if (gy < 0) begin
            gy = -gy;
         end
         edge_hit = (gx > int'(threshold)) || (gy > int'(threshold));
         if (edge_hit && frame_edges < COUNT_MAX) begin
            frame_edges++;
         end
         want.edge_res   = edge_hit;
         want.row_index  = ROW_IDX_W'(r - 2);
         want.col_index  = COL_IDX_W'(c - 2);
         want.edge_count = COUNT_W'(frame_edges);
         want.frame_last = at_end;
         expected_q.push_back(want);
      end
      if (at_end) begin
         at_row = 0;
         at_col = 0;
         frame_edges = 0;
      end else if (c + 1 >= IMAGE_WIDTH) begin
         at_col = 0;
         at_row = r + 1;
      end else begin
         at_col = c + 1;
         at_row = r;
      end
   endtask

   task automatic check_response(input rsp_type got);
      rsp_type want;
      string   where;
      if (expected_q.size() == 0) begin
         report_mismatch("response with no request waiting for it, edge_count",
                         got.edge_count, 0);
      end else begin
         want = expected_q.pop_front();
         where = $sformatf("window (%0d,%0d)", want.row_index, want.col_index);
         if (got.edge_res !== want.edge_res)
            report_mismatch({where, " edge_res"}, got.edge_res, want.edge_res);
         if (got.row_index !== want.row_index)
            report_mismatch({where, " row_index"}, got.row_index, want.row_index);
         if (got.col_index !== want.col_index)
            report_mismatch({where, " col_index"}, got.col_index, want.col_index);
         if (got.edge_count !== want.edge_count)
            report_mismatch({where, " edge_count"}, got.edge_count, want.edge_count);
         if (got.frame_last !== want.frame_last)
            report_mismatch({where, " frame_last"}, got.frame_last, want.frame_last);
      end
      windows_checked++;
      if (got.edge_res === 1'b1) begin
         edges_seen++;
      end
      if (got.frame_last === 1'b1) begin
         frame_ends++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         threshold = THRESHOLD_RESET;
         at_row = 0;
         at_col = 0;
         frame_edges = 0;
         for (int i = 0; i < IMAGE_WIDTH; i++) begin
            store_two_up[i] = '0;
            store_one_up[i] = '0;
         end
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               win[i][j] = '0;
            end
         end
         expected_q.delete();
         mismatch_count = 0;
         windows_checked = 0;
         edges_seen = 0;
         frame_ends = 0;
      end else begin
         // A response at this edge always belongs to an earlier request.
         if (rsp_valid && rsp_ready) begin
            check_response(rsp_data);
         end
         if (req_valid && req_ready) begin
            predict_pixel(req_data);
         end
         if (csr_wr_en) begin
            threshold = csr_wr_data;
         end
      end
      outstanding <= expected_q.size();
   end

endmodule : sobel_edge_checker

// ----- bench/sobel_edge_threshold_tb.sv -----
`timescale 1ns / 100ps
// Top of the Sobel edge threshold testbench: clock, reset, pixel stream,
// response stalls, threshold writes, watchdog and the verdict.
// Depends on sobel_pkg, sobel_edge_threshold and sobel_edge_checker.

module sobel_edge_threshold_tb
   import sobel_pkg::*;
();

   // Rough size of the random part, in pixels.
   localparam int RANDOM_PIXELS   = 750;
   // Longest idle stretch either side draws before a request or a response.
   localparam int MAX_GAP         = 19;
   // Wait after the last expected response, so that pixels that make no
   // response drain out of the pipeline.
   localparam int SETTLE_CYCLES   = 4;
   // Cycles with no handshake on either channel before the run is abandoned.
   localparam int STALL_LIMIT     = 2000;
   // Largest possible absolute Sobel sum for 8-bit pixels.
   localparam int MAX_GRADIENT    = 1020;
   // Two rows plus the start of the third: enough for six windows.
   localparam int DIRECTED_CUT    = 2 * IMAGE_WIDTH + 8;
   // Pixels sent to continue the current row, each completing a window.
   localparam int CONTINUE_PIXELS = 24;

   typedef enum int {
      PAT_VSTEP,
      PAT_HSTEP,
      PAT_FLAT,
      PAT_CHECKER,
      PAT_RAMP,
      PAT_SOFT,
      PAT_NOISE,
      PAT_MIXED
   } pattern_type;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_ready;
   req_type             req_data    = '0;
   logic                rsp_valid;
   logic                rsp_ready   = 1'b0;
   rsp_type             rsp_data;
   logic                csr_wr_en   = 1'b0;
   logic [THRESH_W-1:0] csr_wr_data = '0;

   // When set, neither side inserts idle cycles; it is redrawn every few
   // hundred pixels so that busy stretches and gappy stretches alternate.
   bit steady = 1'b0;

   int pixels_sent        = 0;
   int thresholds_written = 0;
   int idle_cycles        = 0;

   int mismatch_count;
   int outstanding;
   int windows_checked;
   int edges_seen;
   int frame_ends;

   sobel_edge_threshold DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   sobel_edge_checker edge_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .mismatch_count  (mismatch_count),
      .outstanding     (outstanding),
      .windows_checked (windows_checked),
      .edges_seen      (edges_seen),
      .frame_ends      (frame_ends)
   );

   always #1 clock = ~clock;

   // The watchdog restarts on every handshake. The longest legal quiet
   // stretch is a sender gap plus a receiver stall plus the settle pause,
   // far below the limit.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("Watchdog: no handshake for %0d cycles", STALL_LIMIT);
         $display("sobel_edge_threshold_tb NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int unsigned draw_gap();
      if (steady) begin
         return 0;
      end
      return $urandom_range(MAX_GAP, 0);
   endfunction

   // Pixel content of one frame. The step patterns put the largest gradient
   // of 1020 on the boundary, and the vertical stripes also leave windows of
   // gradient zero between boundaries. The flat one gives a gradient of zero,
   // the 2x2 checkerboard gives a strong gradient in every window, the ramp
   // away from its wrap points and the soft pattern give small gradients that
   // sit near typical thresholds, and noise covers every pixel value.
   function automatic logic [PIXEL_W-1:0] pattern_pixel(input pattern_type pat,
                                                        input int r, input int c);
      case (pat)
         PAT_VSTEP:   return ((c % 8) < 4) ? 8'd0 : 8'd255;
         PAT_HSTEP:   return (r == 0) ? 8'd0 : 8'd255;
         PAT_FLAT:    return 8'd255;
         PAT_CHECKER: return ((r / 2 + c / 2) % 2 != 0) ? 8'd255 : 8'd0;
         PAT_RAMP:    return PIXEL_W'(c * 8 + r * 3);
         PAT_SOFT:    return PIXEL_W'(100 + $urandom_range(40, 0));
         default:     return PIXEL_W'($urandom_range(255, 0));
      endcase
   endfunction

   // Offers one request after a random gap and returns at the edge where it
   // is accepted. Valid stays high on return, so the caller must either offer
   // the next request or lower valid in the same time step.
   task automatic send_pixel(input logic [PIXEL_W-1:0] px, input logic fs);
      int unsigned gap;
      req_type     item;
      gap = draw_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      item.pixel = px;
      item.frame_start = fs;
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      pixels_sent++;
   endtask

   // Sends a frame of the given number of rows. A nonzero stop_after cuts it
   // short, which leaves the block mid-frame for whatever follows. Without a
   // frame start the block simply continues from its current position.
   task automatic send_frame(input pattern_type pat, input int rows,
                             input bit with_start, input int stop_after);
      int          total;
      pattern_type row_pat;
      total = rows * IMAGE_WIDTH;
      if (stop_after > 0 && stop_after < total) begin
         total = stop_after;
      end
      row_pat = pat;
      for (int n = 0; n < total; n++) begin
         if (n % 200 == 0) begin
            steady = ($urandom_range(3, 0) == 0);
         end
         if (pat == PAT_MIXED && n % IMAGE_WIDTH == 0) begin
            row_pat = pattern_type'($urandom_range(int'(PAT_NOISE), int'(PAT_VSTEP)));
         end
         send_pixel(pattern_pixel(row_pat, n / IMAGE_WIDTH, n % IMAGE_WIDTH),
                    with_start && n == 0);
      end
   endtask

   // Frame starts on consecutive pixels: the position never gets past the
   // second column, so none of these requests may produce a response.
   task automatic send_start_burst(input int count);
      for (int n = 0; n < count; n++) begin
         send_pixel(PIXEL_W'($urandom_range(255, 0)), 1'b1);
      end
   endtask

   // Stops the stream and waits until every expected response has arrived,
   // then lets pixels without a response drain out of the pipeline.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input int unsigned value);
      settle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= THRESH_W'(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      thresholds_written++;
   endtask

   // Response side: every response waits out its own random stall, and the
   // stall runs whether or not a response is pending.
   initial begin
      int unsigned stall;
      forever begin
         stall = draw_gap();
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      int choice;
      int cut;
      int random_base;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The first frame comes without a frame start, so the
      // block must take its first pixel as row 0, column 0. The threshold is
      // still at its reset value of 128 here.
      send_frame(PAT_VSTEP, 3, 1'b0, DIRECTED_CUT);
      // A zero threshold: the stripes continue the third row, where windows
      // between boundaries have gradient zero, which is not above it, and
      // windows on a boundary are edges.
      write_threshold(0);
      send_frame(PAT_VSTEP, 1, 1'b0, CONTINUE_PIXELS);
      // The largest gradient equals the top threshold and must not count,
      // but it must count one step below. The flat pixels keep the dark top
      // row and bright middle row above them, so the gradient stays at 1020.
      write_threshold(MAX_GRADIENT);
      send_frame(PAT_HSTEP, 3, 1'b1, DIRECTED_CUT);
      write_threshold(MAX_GRADIENT - 1);
      send_frame(PAT_FLAT, 1, 1'b0, CONTINUE_PIXELS);
      send_start_burst(4);

      // Random part: short frames with random content and random thresholds,
      // mixed with frames cut before any window, frames that carry on
      // without a frame start, and bursts of frame starts.
      random_base = pixels_sent;
      while (pixels_sent - random_base < RANDOM_PIXELS) begin
         choice = $urandom_range(9, 0);
         if (choice == 0) begin
            write_threshold(($urandom_range(1, 0) != 0) ? $urandom_range(MAX_GRADIENT, 0)
                                                        : $urandom_range(200, 0));
         end else if (choice == 1) begin
            send_start_burst($urandom_range(4, 1));
         end else begin
            cut = ($urandom_range(3, 0) == 0)
                ? $urandom_range(2 * IMAGE_WIDTH, 1)
                : $urandom_range(2 * IMAGE_WIDTH + 60, 2 * IMAGE_WIDTH + 3);
            send_frame(pattern_type'($urandom_range(int'(PAT_MIXED), int'(PAT_VSTEP))),
                       3, $urandom_range(7, 0) != 0, cut);
         end
      end
      settle();

      $display("Run covered %0d pixels under %0d threshold writes: %0d windows checked,",
               pixels_sent, thresholds_written, windows_checked);
      $display("%0d of them edges, %0d frame ends.", edges_seen, frame_ends);
      if (outstanding != 0) begin
         $display("%0d expected responses never arrived", outstanding);
      end
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("sobel_edge_threshold_tb OK");
      end else begin
         $display("sobel_edge_threshold_tb NOT OK");
      end
      $finish;
   end

endmodule : sobel_edge_threshold_tb
